@@ hw/rtl/max_cycle_mean_karp_macros.svh @@
`ifndef MAX_CYCLE_MEAN_KARP_MACROS_SVH
`define MAX_CYCLE_MEAN_KARP_MACROS_SVH

// same-cycle implication
`define MCMK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mcmk check failed");

// next-cycle implication
`define MCMK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mcmk check failed");

`endif

@@ hw/rtl/mcmk_pkg.sv @@
package mcmk_pkg;

  localparam int unsigned MAX_NODES_DEF   = 64;
  localparam int unsigned WEIGHT_BITS_DEF = 16;
  localparam int unsigned CFG_W           = 7;
  localparam int unsigned FRAC_BITS       = 16;
  localparam logic [2:0]  ADDR_NODE_COUNT = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_R_RD,
    ST_R_AC,
    ST_R_WR,
    ST_M_TOP,
    ST_M_TOPD,
    ST_M_KRD,
    ST_M_KD,
    ST_M_M1,
    ST_M_M2,
    ST_M_VEND,
    ST_B1,
    ST_B2,
    ST_DIV
  } state_e;

endpackage

@@ hw/rtl/mcmk_ram.sv @@
module mcmk_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hw/rtl/max_cycle_mean_karp.sv @@
// Maximum cycle mean (Karp) over an n-by-n weight matrix, walks seeded from node 0.
// Weights stream in one word per cycle while in_stall_o is low, row-major by source node,
// into a weight RAM; a zero weight means no edge. The word flagged last_entry starts the
// computation and the block stalls its input until the single result word is out. Row 0
// of the walk table is seeded first; the table build then reads predecessors through the
// weight and walk-table RAM read ports, the min/max pass runs its exact ratio compares
// through one shared multiplier, and a one-bit-per-cycle divider forms mean_q16. If no
// node has a finite mean, valid_res is 0 and the other fields are 0.
// node_count (offset 0) is to be written by the user only while idle; the block itself
// does not enforce it. A value of 0 is used as 1, large values as MAX_NODES.
module max_cycle_mean_karp #(
  parameter int unsigned MAX_NODES   = mcmk_pkg::MAX_NODES_DEF,
  parameter int unsigned WEIGHT_BITS = mcmk_pkg::WEIGHT_BITS_DEF,
  localparam int unsigned TBL_W   = WEIGHT_BITS + $clog2(MAX_NODES) + 1,
  localparam int unsigned LEN_W   = $clog2(MAX_NODES + 1),
  localparam int unsigned DIV_W   = TBL_W + mcmk_pkg::FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [WEIGHT_BITS-1:0] edge_weight_i,
  input  logic                   last_entry_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   valid_res_o,
  output logic signed [DIV_W-1:0] mean_q16_o,
  output logic signed [TBL_W-1:0] best_numerator_o,
  output logic [LEN_W-1:0]       best_length_o
);

  localparam int unsigned STORE_DEPTH = MAX_NODES * MAX_NODES;
  localparam int unsigned TABLE_DEPTH = (MAX_NODES + 1) * MAX_NODES;
  localparam int unsigned WADDR_W = $clog2(STORE_DEPTH);
  localparam int unsigned TADDR_W = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W   = $clog2(MAX_NODES);
  localparam int unsigned PROD_W  = TBL_W + LEN_W + 1;
  localparam int unsigned CNT_W   = $clog2(DIV_W);
  localparam int unsigned CFG_W   = mcmk_pkg::CFG_W;
  localparam int unsigned FRAC    = mcmk_pkg::FRAC_BITS;

  mcmk_pkg::state_e state_q, state_d;

  logic [CFG_W-1:0]   cfg_n_q;
  logic [LEN_W-1:0]   n_q, n_d, nm1;
  logic [WADDR_W-1:0] load_q, load_d, wa_q, wa_d;
  logic [TADDR_W-1:0] ta_q, ta_d, cell_q, cell_d, base_q, base_d;
  logic [IDX_W-1:0]   v_q, v_d, src_q, src_d;
  logic [LEN_W-1:0]   k_q, k_d;
  logic signed [TBL_W-1:0] acc_q, acc_d, top_q, top_d, num_q, num_d;
  logic signed [TBL_W-1:0] min_num_q, min_num_d, best_num_q, best_num_d;
  logic [LEN_W-1:0]   len_q, len_d, min_len_q, min_len_d, best_len_q, best_len_d;
  logic               acc_ex_q, acc_ex_d, have_q, have_d, found_q, found_d;
  logic signed [PROD_W-1:0] prod_q, prod_d, mul_p;
  logic signed [TBL_W-1:0]  mul_a;
  logic [LEN_W-1:0]   mul_b;
  logic [LEN_W:0]     rem_q, rem_d, rem_sh;
  logic [DIV_W-1:0]   quot_q, quot_d;
  logic               neg_q, neg_d;
  logic [CNT_W-1:0]   dcnt_q, dcnt_d;
  logic               ov_q, ov_d, vr_q, vr_d;
  logic signed [DIV_W-1:0] mean_q, mean_d;
  logic signed [TBL_W-1:0] onum_q, onum_d;
  logic [LEN_W-1:0]   olen_q, olen_d;

  logic               w_we, t_we;
  logic [TBL_W:0]     t_wdata, t_rdata;
  logic [TADDR_W-1:0] t_raddr;
  logic [WEIGHT_BITS-1:0] w_rdata;
  logic signed [TBL_W-1:0] t_val, cand;
  logic               t_ex, accept, k_adv, v_next;
  logic [TBL_W-1:0]   abs_num;

  mcmk_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(STORE_DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (load_q),
    .wdata_i (edge_weight_i),
    .raddr_i (wa_q),
    .rdata_o (w_rdata)
  );

  mcmk_ram #(.WIDTH(TBL_W + 1), .DEPTH(TABLE_DEPTH)) u_walk_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (cell_q),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  assign pready      = 1'b1;
  assign prdata      = (paddr == mcmk_pkg::ADDR_NODE_COUNT) ? 32'(cfg_n_q) : 32'd0;
  assign in_stall_o  = (state_q != mcmk_pkg::ST_IDLE) || ov_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign w_we        = accept;
  assign out_valid_o = ov_q;
  assign valid_res_o = vr_q;
  assign mean_q16_o  = mean_q;
  assign best_numerator_o = onum_q;
  assign best_length_o    = olen_q;

  assign nm1    = n_q - 1'b1;
  assign t_val  = $signed(t_rdata[TBL_W-1:0]);
  assign t_ex   = t_rdata[TBL_W];
  assign cand   = t_val + $signed({{(TBL_W - WEIGHT_BITS){1'b0}}, w_rdata});
  assign mul_p  = $signed(PROD_W'(mul_a)) * $signed(PROD_W'({1'b0, mul_b}));
  assign rem_sh = {rem_q[LEN_W-1:0], quot_q[DIV_W-1]};
  assign abs_num = best_num_d[TBL_W-1] ? TBL_W'(-best_num_d) : TBL_W'(best_num_d);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      mcmk_pkg::ST_M_M1: begin mul_a = min_num_q;  mul_b = len_q;      end
      mcmk_pkg::ST_M_M2: begin mul_a = num_q;      mul_b = min_len_q;  end
      mcmk_pkg::ST_B1:   begin mul_a = min_num_q;  mul_b = best_len_q; end
      mcmk_pkg::ST_B2:   begin mul_a = best_num_q; mul_b = min_len_q;  end
      default: ;
    endcase
  end

  always_comb begin
    t_raddr = ta_q;
    if (state_q == mcmk_pkg::ST_M_TOP) begin
      t_raddr = base_q + TADDR_W'(v_q);
    end
  end

  always_comb begin
    state_d = state_q;
    n_d = n_q; load_d = load_q; wa_d = wa_q; ta_d = ta_q; cell_d = cell_q;
    base_d = base_q; v_d = v_q; src_d = src_q; k_d = k_q;
    acc_d = acc_q; acc_ex_d = acc_ex_q; top_d = top_q; num_d = num_q; len_d = len_q;
    min_num_d = min_num_q; min_len_d = min_len_q; have_d = have_q;
    best_num_d = best_num_q; best_len_d = best_len_q; found_d = found_q;
    prod_d = prod_q; rem_d = rem_q; quot_d = quot_q; neg_d = neg_q; dcnt_d = dcnt_q;
    ov_d = ov_q; vr_d = vr_q; mean_d = mean_q; onum_d = onum_q; olen_d = olen_q;
    t_we = 1'b0;
    t_wdata = {acc_ex_q, acc_q};
    k_adv = 1'b0;
    v_next = 1'b0;

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    case (state_q)
      mcmk_pkg::ST_IDLE: begin
        if (accept) begin
          load_d = (32'(load_q) == STORE_DEPTH - 1) ? '0 : load_q + 1'b1;
          if (last_entry_i) begin
            load_d = '0;
            if (cfg_n_q == '0) begin
              n_d = LEN_W'(1);
            end else if (32'(cfg_n_q) > MAX_NODES) begin
              n_d = LEN_W'(MAX_NODES);
            end else begin
              n_d = LEN_W'(cfg_n_q);
            end
            v_d = '0;
            cell_d = '0;
            state_d = mcmk_pkg::ST_INIT;
          end
        end
      end
      mcmk_pkg::ST_INIT: begin
        t_we = 1'b1;
        t_wdata = {(v_q == '0), {TBL_W{1'b0}}};
        cell_d = cell_q + 1'b1;
        v_d = v_q + 1'b1;
        if (v_q == nm1[IDX_W-1:0]) begin
          v_d = '0;
          src_d = '0;
          k_d = LEN_W'(1);
          wa_d = '0;
          ta_d = '0;
          base_d = '0;
          acc_ex_d = 1'b0;
          state_d = mcmk_pkg::ST_R_RD;
        end
      end
      mcmk_pkg::ST_R_RD: begin
        state_d = mcmk_pkg::ST_R_AC;
      end
      mcmk_pkg::ST_R_AC: begin
        if (w_rdata != '0 && t_ex && (!acc_ex_q || cand > acc_q)) begin
          acc_d = cand;
          acc_ex_d = 1'b1;
        end
        if (src_q == nm1[IDX_W-1:0]) begin
          state_d = mcmk_pkg::ST_R_WR;
        end else begin
          src_d = src_q + 1'b1;
          wa_d = wa_q + WADDR_W'(n_q);
          ta_d = ta_q + 1'b1;
          state_d = mcmk_pkg::ST_R_RD;
        end
      end
      mcmk_pkg::ST_R_WR: begin
        t_we = 1'b1;
        cell_d = cell_q + 1'b1;
        acc_ex_d = 1'b0;
        acc_d = '0;
        src_d = '0;
        state_d = mcmk_pkg::ST_R_RD;
        if (v_q == nm1[IDX_W-1:0]) begin
          v_d = '0;
          wa_d = '0;
          base_d = base_q + TADDR_W'(n_q);
          ta_d = base_q + TADDR_W'(n_q);
          if (k_q == n_q) begin
            found_d = 1'b0;
            best_num_d = '0;
            best_len_d = LEN_W'(1);
            state_d = mcmk_pkg::ST_M_TOP;
          end else begin
            k_d = k_q + 1'b1;
          end
        end else begin
          v_d = v_q + 1'b1;
          wa_d = WADDR_W'(v_q) + 1'b1;
          ta_d = base_q;
        end
      end
      mcmk_pkg::ST_M_TOP: begin
        state_d = mcmk_pkg::ST_M_TOPD;
      end
      mcmk_pkg::ST_M_TOPD: begin
        top_d = t_val;
        if (!t_ex) begin
          v_next = 1'b1;
        end else begin
          k_d = '0;
          ta_d = TADDR_W'(v_q);
          have_d = 1'b0;
          state_d = mcmk_pkg::ST_M_KRD;
        end
      end
      mcmk_pkg::ST_M_KRD: begin
        state_d = mcmk_pkg::ST_M_KD;
      end
      mcmk_pkg::ST_M_KD: begin
        if (t_ex) begin
          if (!have_q) begin
            min_num_d = top_q - t_val;
            min_len_d = n_q - k_q;
            have_d = 1'b1;
            k_adv = 1'b1;
          end else begin
            num_d = top_q - t_val;
            len_d = n_q - k_q;
            state_d = mcmk_pkg::ST_M_M1;
          end
        end else begin
          k_adv = 1'b1;
        end
      end
      mcmk_pkg::ST_M_M1: begin
        prod_d = mul_p;
        state_d = mcmk_pkg::ST_M_M2;
      end
      mcmk_pkg::ST_M_M2: begin
        if (prod_q > mul_p) begin
          min_num_d = num_q;
          min_len_d = len_q;
        end
        k_adv = 1'b1;
      end
      mcmk_pkg::ST_M_VEND: begin
        if (!have_q) begin
          v_next = 1'b1;
        end else if (!found_q) begin
          best_num_d = min_num_q;
          best_len_d = min_len_q;
          found_d = 1'b1;
          v_next = 1'b1;
        end else begin
          state_d = mcmk_pkg::ST_B1;
        end
      end
      mcmk_pkg::ST_B1: begin
        prod_d = mul_p;
        state_d = mcmk_pkg::ST_B2;
      end
      mcmk_pkg::ST_B2: begin
        if (prod_q > mul_p) begin
          best_num_d = min_num_q;
          best_len_d = min_len_q;
        end
        v_next = 1'b1;
      end
      mcmk_pkg::ST_DIV: begin
        dcnt_d = dcnt_q + 1'b1;
        if (rem_sh >= {1'b0, best_len_q}) begin
          rem_d = rem_sh - {1'b0, best_len_q};
          quot_d = {quot_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          quot_d = {quot_q[DIV_W-2:0], 1'b0};
        end
        if (32'(dcnt_q) == DIV_W - 1) begin
          ov_d = 1'b1;
          vr_d = 1'b1;
          mean_d = neg_q ? $signed(-quot_d) : $signed(quot_d);
          onum_d = best_num_q;
          olen_d = best_len_q;
          state_d = mcmk_pkg::ST_IDLE;
        end
      end
      default: state_d = mcmk_pkg::ST_IDLE;
    endcase

    if (k_adv) begin
      if (k_q == nm1) begin
        state_d = mcmk_pkg::ST_M_VEND;
      end else begin
        k_d = k_q + 1'b1;
        ta_d = ta_q + TADDR_W'(n_q);
        state_d = mcmk_pkg::ST_M_KRD;
      end
    end

    if (v_next) begin
      if (v_q == nm1[IDX_W-1:0]) begin
        if (!found_d) begin
          ov_d = 1'b1;
          vr_d = 1'b0;
          mean_d = '0;
          onum_d = '0;
          olen_d = '0;
          state_d = mcmk_pkg::ST_IDLE;
        end else begin
          neg_d = best_num_d[TBL_W-1];
          quot_d = {abs_num, {FRAC{1'b0}}};
          rem_d = '0;
          dcnt_d = '0;
          state_d = mcmk_pkg::ST_DIV;
        end
      end else begin
        v_d = v_q + 1'b1;
        state_d = mcmk_pkg::ST_M_TOP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcmk_pkg::ST_IDLE;
      cfg_n_q <= CFG_W'(1);
      load_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      ov_q    <= ov_d;
      if (psel && penable && pwrite && paddr == mcmk_pkg::ADDR_NODE_COUNT) begin
        cfg_n_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; wa_q <= wa_d; ta_q <= ta_d; cell_q <= cell_d; base_q <= base_d;
    v_q <= v_d; src_q <= src_d; k_q <= k_d;
    acc_q <= acc_d; acc_ex_q <= acc_ex_d; top_q <= top_d; num_q <= num_d; len_q <= len_d;
    min_num_q <= min_num_d; min_len_q <= min_len_d; have_q <= have_d;
    best_num_q <= best_num_d; best_len_q <= best_len_d; found_q <= found_d;
    prod_q <= prod_d; rem_q <= rem_d; quot_q <= quot_d; neg_q <= neg_d; dcnt_q <= dcnt_d;
    vr_q <= vr_d; mean_q <= mean_d; onum_q <= onum_d; olen_q <= olen_d;
  end

`include "max_cycle_mean_karp_macros.svh"

  `MCMK_ASSERT_NOW(a_empty_zero, out_valid_o && !valid_res_o,
                   mean_q16_o == '0 && best_numerator_o == '0 && best_length_o == '0)
  `MCMK_ASSERT_NOW(a_len_range, out_valid_o && valid_res_o, best_length_o != '0 && best_length_o <= n_q)
  `MCMK_ASSERT_NEXT(a_start, accept && last_entry_i,
                    state_q == mcmk_pkg::ST_INIT && load_q == '0)

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NMAX   = mcmk_pkg::MAX_NODES_DEF;
  localparam int unsigned WB     = mcmk_pkg::WEIGHT_BITS_DEF;
  localparam int unsigned TBL_W  = WB + $clog2(NMAX) + 1;
  localparam int unsigned LEN_W  = $clog2(NMAX + 1);
  localparam int unsigned DIV_W  = TBL_W + mcmk_pkg::FRAC_BITS;
  localparam int unsigned DEPTH  = NMAX * NMAX;
  localparam int unsigned LOAD_N = 16;

  typedef struct packed {
    logic                    valid_res;
    logic signed [DIV_W-1:0] mean_q16;
    logic signed [TBL_W-1:0] best_numerator;
    logic [LEN_W-1:0]        best_length;
  } cycle_mean_t;

  class cycle_mean_sb;
    logic [WB-1:0] weights [DEPTH];
    longint        walk [(NMAX + 1) * NMAX];
    bit            reach [(NMAX + 1) * NMAX];
    int unsigned   wr_pos;
    int unsigned   node_cnt;
    cycle_mean_t   pending_q [$];
    int            errors;
    int            n_results;
    int            n_valid;

    function new();
      wr_pos    = 0;
      node_cnt  = 1;
      errors    = 0;
      n_results = 0;
      n_valid   = 0;
    endfunction

    function void set_node_count(int unsigned value);
      node_cnt = value & 7'h7f;
    endfunction

    function void note_word(logic [WB-1:0] w, logic last);
      int unsigned n;
      int unsigned top;
      int unsigned cidx;
      int unsigned pidx;
      longint      cand;
      longint      min_num;
      longint      min_len;
      longint      best_num;
      longint      best_len;
      longint      num;
      longint      len;
      bit          have_min;
      bit          found;
      cycle_mean_t res;
      weights[wr_pos] = w;
      wr_pos = (wr_pos + 1) % DEPTH;
      if (!last) return;
      wr_pos = 0;
      n = node_cnt;
      if (n < 1) n = 1;
      if (n > NMAX) n = NMAX;
      for (int v = 0; v < n; v++) begin
        walk[v]  = 0;
        reach[v] = (v == 0);
      end
      for (int k = 1; k <= n; k++) begin
        for (int v = 0; v < n; v++) begin
          cidx = k * n + v;
          reach[cidx] = 0;
          walk[cidx]  = 0;
          for (int s = 0; s < n; s++) begin
            pidx = (k - 1) * n + s;
            if (weights[s * n + v] == 0 || !reach[pidx]) continue;
            cand = walk[pidx] + longint'(weights[s * n + v]);
            if (!reach[cidx] || cand > walk[cidx]) begin
              walk[cidx]  = cand;
              reach[cidx] = 1;
            end
          end
        end
      end
      found    = 0;
      best_num = 0;
      best_len = 1;
      for (int v = 0; v < n; v++) begin
        top = n * n + v;
        if (!reach[top]) continue;
        have_min = 0;
        min_num  = 0;
        min_len  = 1;
        for (int k = 0; k < n; k++) begin
          cidx = k * n + v;
          if (!reach[cidx]) continue;
          num = walk[top] - walk[cidx];
          len = n - k;
          if (!have_min || min_num * len > num * min_len) begin
            min_num  = num;
            min_len  = len;
            have_min = 1;
          end
        end
        if (!have_min) continue;
        if (!found || min_num * best_len > best_num * min_len) begin
          best_num = min_num;
          best_len = min_len;
          found    = 1;
        end
      end
      res = '0;
      if (found) begin
        res.valid_res      = 1'b1;
        res.mean_q16       = DIV_W'((best_num * 65536) / best_len);
        res.best_numerator = TBL_W'(best_num);
        res.best_length    = LEN_W'(best_len);
      end
      pending_q = {pending_q, res};
    endfunction

    function void check_word(cycle_mean_t act);
      cycle_mean_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      n_results++;
      if (exp_r.valid_res) n_valid++;
      if (act.valid_res !== exp_r.valid_res) begin
        $error("valid_res exp %0d got %0d", exp_r.valid_res, act.valid_res);
        errors++;
      end
      if (act.mean_q16 !== exp_r.mean_q16) begin
        $error("mean_q16 exp %0d got %0d", exp_r.mean_q16, act.mean_q16);
        errors++;
      end
      if (act.best_numerator !== exp_r.best_numerator) begin
        $error("best_numerator exp %0d got %0d", exp_r.best_numerator,
               act.best_numerator);
        errors++;
      end
      if (act.best_length !== exp_r.best_length) begin
        $error("best_length exp %0d got %0d", exp_r.best_length, act.best_length);
        errors++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [2:0]              paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [WB-1:0]           edge_weight_i = '0;
  logic                    last_entry_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    valid_res_o;
  logic signed [DIV_W-1:0] mean_q16_o;
  logic signed [TBL_W-1:0] best_numerator_o;
  logic [LEN_W-1:0]        best_length_o;

  cycle_mean_sb sb = new();
  int           burst_left = 0;
  int           stall_mode = 0;
  int           n_words = 0;

  max_cycle_mean_karp u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .edge_weight_i, .last_entry_i,
    .out_valid_o, .out_stall_i, .valid_res_o, .mean_q16_o, .best_numerator_o,
    .best_length_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check_word({valid_res_o, mean_q16_o, best_numerator_o, best_length_o});
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 9) != 0);
    endcase
  end

  task automatic send_word(input logic [WB-1:0] w, input logic last);
    in_valid_i    <= 1'b1;
    edge_weight_i <= w;
    last_entry_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(w, last);
    n_words++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i    <= 1'b0;
        edge_weight_i <= WB'($urandom);
        last_entry_i  <= 1'($urandom);
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_node_count(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mcmk_pkg::ADDR_NODE_COUNT;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_node_count(value);
    @(posedge clk_i);
  endtask

  function automatic logic [WB-1:0] rand_weight();
    case ($urandom_range(0, 9))
      0, 1, 2: return '0;
      3:       return '1;
      4:       return WB'(1);
      default: return WB'($urandom);
    endcase
  endfunction

  task automatic load_matrix(input int unsigned count);
    for (int i = 0; i < count; i++)
      send_word(rand_weight(), i == count - 1);
  endtask

  initial begin
    int unsigned n;
    int unsigned cnt;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // load every word that any later node count up to LOAD_N can read
    write_node_count(LOAD_N);
    load_matrix(LOAD_N * LOAD_N);
    drain();
    write_node_count(0);
    send_word('1, 1'b1);
    drain();
    write_node_count(1);
    send_word('0, 1'b1);
    drain();
    write_node_count(2);
    send_word('0, 1'b0);
    send_word('1, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word('1, 1'b1);
    send_word(16'h5555, 1'b0);
    send_word('0, 1'b0);
    send_word('0, 1'b0);
    send_word(16'haaaa, 1'b1);
    drain();
    write_node_count(3);
    send_word(16'h0007, 1'b0);
    send_word(16'h8000, 1'b1);
    drain();

    while (n_words < 1050) begin
      if ($urandom_range(0, 3) == 0) begin
        drain();
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        write_node_count(n);
      end
      n = sb.node_cnt;
      if (n < 1) n = 1;
      if (n > NMAX) n = NMAX;
      case ($urandom_range(0, 9))
        0:       cnt = $urandom_range(1, n * n);
        1:       cnt = n * n + $urandom_range(1, 5);
        default: cnt = n * n;
      endcase
      if ($urandom_range(0, 15) == 0)
        repeat ($urandom_range(1, 4)) send_word(rand_weight(), 1'b0);
      load_matrix(cnt);
      if ($urandom_range(0, 9) == 0) drain();
    end
    drain();
    repeat (200) @(posedge clk_i);

    $display("Ran %0d input words, %0d results (%0d with a finite mean).",
             n_words, sb.n_results, sb.n_valid);
    $display("Node counts covered 0 and 1..16, with short, full and overlong loads.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.pending_q.size() != 0)
        $error("%0d results never arrived", sb.pending_q.size());
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #500ms;
    $display("FAILURE");
    $finish;
  end

endmodule
